>>> rtl/ascii_weight_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII weight frame decoder
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASCII_WEIGHT_FRAME_DECODER_ASSERT_SVH
`define ASCII_WEIGHT_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define AWFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awfd assertion failed");

// next-cycle implication
`define AWFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awfd assertion failed");

`endif

>>> rtl/awfd_pkg.sv
// ----------------------------------------------------------------------------
// awfd_pkg
// Shared constants and types of the ASCII weight frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awfd_pkg;

  localparam int FRAME_MAX   = 16;
  localparam int STORE_DEPTH = 7;
  localparam int STORE_FIRST = 3;
  localparam int STORE_LAST  = STORE_FIRST + STORE_DEPTH - 1;
  localparam int COUNT_W     = 5;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // store entry 3 is the decimal point position and carries no weight
  localparam logic [31:0] PLACE_WEIGHT [STORE_DEPTH] = '{
    32'd100000, 32'd10000, 32'd1000, 32'd0, 32'd100, 32'd10, 32'd1
  };

  typedef logic [STORE_DEPTH-1:0][7:0] digits_t;

  typedef struct packed {
    logic    closing;
    digits_t digits;
  } frm_status_t;

endpackage

>>> rtl/awfd_frame.sv
// ----------------------------------------------------------------------------
// awfd_frame
// Frame tracker: open/close state, byte count and the digit store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awfd_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  output awfd_pkg::frm_status_t status
);

  logic                            frame_open;
  logic                            frame_open_next;
  logic [awfd_pkg::COUNT_W-1:0]    byte_count;
  logic [awfd_pkg::COUNT_W-1:0]    byte_count_next;
  awfd_pkg::digits_t               digit_store;
  awfd_pkg::digits_t               written;
  awfd_pkg::digits_t               fixed;
  logic [awfd_pkg::COUNT_W-1:0]    offs;
  logic                            in_store;
  logic                            overflow;
  logic                            closing;

  assign offs     = byte_count - awfd_pkg::COUNT_W'(awfd_pkg::STORE_FIRST);
  assign in_store = (byte_count >= awfd_pkg::COUNT_W'(awfd_pkg::STORE_FIRST)) &&
                    (byte_count <= awfd_pkg::COUNT_W'(awfd_pkg::STORE_LAST));

  always_comb begin
    written         = digit_store;
    frame_open_next = frame_open;
    byte_count_next = '0;
    if (frame_open) begin
      if (in_store) begin
        written[offs[awfd_pkg::IDX_W-1:0]] = rx_byte;
      end
      byte_count_next = byte_count + 1'b1;
    end else if (rx_byte == awfd_pkg::CH_MINUS || rx_byte == awfd_pkg::CH_PLUS) begin
      frame_open_next = 1'b1;
      byte_count_next = awfd_pkg::COUNT_W'(1);
    end
    overflow = byte_count_next > awfd_pkg::COUNT_W'(awfd_pkg::FRAME_MAX);
    closing  = frame_open && (rx_byte == awfd_pkg::CH_LF) && !overflow;
    // drop an overlong frame, end a closed one
    if (overflow || closing) begin
      frame_open_next = 1'b0;
      byte_count_next = '0;
    end
  end

  // up to two blank leading digits read as zero
  always_comb begin
    fixed = written;
    if (written[0] == awfd_pkg::CH_SPACE) begin
      fixed[0] = awfd_pkg::CH_ZERO;
      if (written[1] == awfd_pkg::CH_SPACE) begin
        fixed[1] = awfd_pkg::CH_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      byte_count  <= '0;
      digit_store <= '0;
    end else if (step) begin
      frame_open  <= frame_open_next;
      byte_count  <= byte_count_next;
      digit_store <= closing ? fixed : written;
    end
  end

  assign status.closing = closing;
  assign status.digits  = fixed;

endmodule

>>> rtl/awfd_weigh.sv
// ----------------------------------------------------------------------------
// awfd_weigh
// Weighted digit sum of a closed frame, wrapped to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awfd_weigh (
  input  awfd_pkg::digits_t digits,
  input  logic              coarse_mode,
  output logic [31:0]       weight
);

  logic [31:0] term [awfd_pkg::STORE_DEPTH];

  always_comb begin
    for (int i = 0; i < awfd_pkg::STORE_DEPTH; i++) begin
      // byte minus '0' as a signed digit, modulo 2^32
      term[i] = ({24'd0, digits[i]} - 32'd48) * awfd_pkg::PLACE_WEIGHT[i];
    end
    // coarse mode drops the last digit
    if (coarse_mode) begin
      term[awfd_pkg::STORE_DEPTH-1] = '0;
    end
    weight = '0;
    for (int i = 0; i < awfd_pkg::STORE_DEPTH; i++) begin
      weight = weight + term[i];
    end
  end

endmodule

>>> rtl/ascii_weight_frame_decoder.sv
// ----------------------------------------------------------------------------
// ascii_weight_frame_decoder
// Decodes ASCII scale frames into a 32-bit weight, one byte per beat.
// ----------------------------------------------------------------------------
// One received byte per beat; a byte enters the input register and is
// processed from there, so a new byte is taken every cycle unless stalled.
// The weight of a frame is loaded into the output register at the edge that
// processes its line feed. Throughput is one byte per cycle, set by the frame
// tracker and digit sum; the only stall is a closing byte that meets a result
// still held in the output register. The user must write coarse_mode with
// cfg_wr_en only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module ascii_weight_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        coarse_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] weight_value
);

  logic                  coarse;
  logic                  in_q_valid;
  logic [7:0]            in_q_byte;
  logic                  process;
  logic [31:0]           weight;
  awfd_pkg::frm_status_t status;

  awfd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (process),
    .rx_byte (in_q_byte),
    .status  (status)
  );

  awfd_weigh u_weigh (
    .digits      (status.digits),
    .coarse_mode (coarse),
    .weight      (weight)
  );

  // hold a closing byte while the output register is full and not drained
  assign process  = in_q_valid && (!status.closing || !out_valid || out_ready);
  assign in_ready = !in_q_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      coarse <= 1'b0;
    end else if (cfg_wr_en) begin
      coarse <= coarse_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && status.closing) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && status.closing) begin
      weight_value <= weight;
    end
  end

endmodule

>>> rtl/awfd_checker.sv
// ----------------------------------------------------------------------------
// awfd_checker
// Port-level checks of the ASCII weight frame decoder, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_weight_frame_decoder_assert.svh"

module awfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic        coarse_mode,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] weight_value
);

  // a stalled result holds its value
  `AWFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(weight_value))

  // input side never stalls while the output can drain
  `AWFD_ASSERT_NOW(a_ready_when_drained, !out_valid || out_ready, in_ready)

  // no result right after reset
  `AWFD_ASSERT_NOW(a_quiet_after_reset, $past(rst), !out_valid)

endmodule

bind ascii_weight_frame_decoder awfd_checker u_awfd_checker (.*);
